FILE: design/tdf_pkg.sv
// ============================================================================
// tdf_pkg
// Shared constants, types and helpers for the timestamp delay FIFO.
// ============================================================================
`default_nettype none

package tdf_pkg;

    // Buffer geometry. DEPTH may be any value from 2 to 4096.
    localparam int unsigned DEPTH     = 64;
    localparam int unsigned ADDR_W    = $clog2(DEPTH);
    localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

    // Field widths.
    localparam int unsigned STAMP_W   = 40;
    localparam int unsigned PAYLOAD_W = 32;
    localparam int unsigned DELAY_W   = 24;
    localparam int unsigned ENTRY_W   = STAMP_W + PAYLOAD_W;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd100000;

    // One stored message.
    typedef struct packed {
        logic [STAMP_W-1:0]   stamp;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

    // One released message as it travels to the output stage.
    typedef struct packed {
        logic [STAMP_W-1:0]   stamp;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last;
    } t_result;

    // Circular pointer advance; DEPTH need not be a power of two.
    function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] ptr);
        logic [ADDR_W-1:0] nxt;
        if (ptr == ADDR_W'(DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

FILE: design/tdf_ram.sv
// ============================================================================
// tdf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ============================================================================
`default_nettype none

module tdf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: design/tdf_out_stage.sv
// ============================================================================
// tdf_out_stage
// Output register that decouples the sequencer from the receiver.
// ============================================================================
`default_nettype none

module tdf_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire tdf_pkg::t_result i_push_data,
    output logic                  o_free,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tdf_pkg::t_result      o_out_data
);
    import tdf_pkg::*;

    logic    r_valid;
    t_result r_data;

    // The slot can take a new result when empty or when it empties this cycle.
    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_push_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

FILE: design/tdf_seq.sv
// ============================================================================
// tdf_seq
// Sequencer: writes messages into the buffer RAM and releases the oldest
// entries while the span exceeds the delay. One released entry is held back
// until it is known whether it is the last one for the current input.
// ============================================================================
`default_nettype none

module tdf_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [tdf_pkg::DELAY_W-1:0]     i_delay_us,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [tdf_pkg::STAMP_W-1:0]     i_in_stamp,
    input  wire logic [tdf_pkg::PAYLOAD_W-1:0]   i_in_payload,
    output logic                                 o_wr_en,
    output logic      [tdf_pkg::ADDR_W-1:0]      o_wr_addr,
    output tdf_pkg::t_entry                      o_wr_data,
    output logic                                 o_rd_en,
    output logic      [tdf_pkg::ADDR_W-1:0]      o_rd_addr,
    input  wire tdf_pkg::t_entry                 i_rd_data,
    input  wire logic                            i_out_free,
    output logic                                 o_push,
    output tdf_pkg::t_result                     o_push_data
);
    import tdf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FPOP,
        S_FDATA,
        S_WR,
        S_CHK_RD,
        S_CHK,
        S_FLUSH
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_rd_ptr;
    logic [ADDR_W-1:0]   r_wr_ptr;
    logic [CNT_W-1:0]    r_count;
    logic [STAMP_W-1:0]  r_stamp;
    logic [PAYLOAD_W-1:0] r_payload;
    logic                r_pend_valid;
    t_entry              r_pend;

    logic [STAMP_W-1:0]  span;
    logic                span_over;
    logic                chk_emit;
    logic                full;

    assign full      = (r_count == CNT_W'(DEPTH));
    assign span      = r_stamp - i_rd_data.stamp;
    assign span_over = (span > STAMP_W'(i_delay_us));
    // Releasing another entry pushes the held one out as a non-final result.
    assign chk_emit  = (r_state == S_CHK) && span_over && r_pend_valid;

    assign o_in_ready = (r_state == S_IDLE);

    assign o_rd_en   = (r_state == S_FPOP) || (r_state == S_CHK_RD);
    assign o_rd_addr = r_rd_ptr;
    assign o_wr_en   = (r_state == S_WR);
    assign o_wr_addr = r_wr_ptr;
    assign o_wr_data = '{stamp: r_stamp, payload: r_payload};

    assign o_push = i_out_free &&
                    (chk_emit || ((r_state == S_FLUSH) && r_pend_valid));
    assign o_push_data = '{stamp:   r_pend.stamp,
                           payload: r_pend.payload,
                           last:    (r_state == S_FLUSH)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_stamp   <= i_in_stamp;
                        r_payload <= i_in_payload;
                        if (i_delay_us == '0) begin
                            r_pend       <= '{stamp: i_in_stamp, payload: i_in_payload};
                            r_pend_valid <= 1'b1;
                            r_state      <= S_FLUSH;
                        end else if (full) begin
                            r_state <= S_FPOP;
                        end else begin
                            r_state <= S_WR;
                        end
                    end
                end
                S_FPOP: begin
                    r_rd_ptr <= next_ptr(r_rd_ptr);
                    r_count  <= r_count - 1'b1;
                    r_state  <= S_FDATA;
                end
                S_FDATA: begin
                    r_pend       <= i_rd_data;
                    r_pend_valid <= 1'b1;
                    r_state      <= S_WR;
                end
                S_WR: begin
                    r_wr_ptr <= next_ptr(r_wr_ptr);
                    r_count  <= r_count + 1'b1;
                    if (r_count != '0) begin
                        r_state <= S_CHK_RD;
                    end else begin
                        r_state <= S_FLUSH;
                    end
                end
                S_CHK_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (span_over) begin
                        if (!r_pend_valid || i_out_free) begin
                            r_pend       <= i_rd_data;
                            r_pend_valid <= 1'b1;
                            r_rd_ptr     <= next_ptr(r_rd_ptr);
                            r_count      <= r_count - 1'b1;
                            if (r_count > CNT_W'(2)) begin
                                r_state <= S_CHK_RD;
                            end else begin
                                r_state <= S_FLUSH;
                            end
                        end
                    end else begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_valid || i_out_free) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/timestamp_delay_fifo.sv
// ============================================================================
// timestamp_delay_fifo
// Delay line that holds timestamped messages until the buffered span
// exceeds a programmable delay.
// ============================================================================
// Usage:
// Input transactions (i_in_valid / o_in_ready) carry a 40-bit microsecond
// stamp and a 32-bit payload. Output transactions (o_out_valid / i_out_ready)
// carry released messages; o_out_last marks the final message released for
// one input. An input may release nothing, one message or up to DEPTH.
// The delay register is written through i_cfg_valid / o_cfg_ready, which is
// always ready; write it only while the block is idle. Zero means passthrough.
// Sequence: one input is processed at a time. A passthrough transaction goes
// straight to the output; a buffered one first pops the oldest entry when
// the buffer is full, then writes the new entry and runs a span check
// against the oldest entry for every message the drain releases, and one
// that stops the drain unless it has come down to a single entry. Each span
// check waits for the registered read data of the buffer RAM.
// Reset empties the buffer (pointers and fill count cleared, no RAM sweep)
// and loads the delay with 100000 us. A stalled receiver holds the result
// in the output register; the sequencer then waits before pushing the next.
// ============================================================================
`default_nettype none

module timestamp_delay_fifo (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tdf_pkg::DELAY_W-1:0]     i_cfg_delay_us,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [tdf_pkg::STAMP_W-1:0]     i_in_stamp,
    input  wire logic [tdf_pkg::PAYLOAD_W-1:0]   i_in_payload,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [tdf_pkg::STAMP_W-1:0]     o_out_stamp,
    output logic      [tdf_pkg::PAYLOAD_W-1:0]   o_out_payload,
    output logic                                 o_out_last
);
    import tdf_pkg::*;

    // Delay register. The port never stalls a configuration transaction.
    logic [DELAY_W-1:0] r_delay_us;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_us <= DELAY_RESET;
        end else if (i_cfg_valid) begin
            r_delay_us <= i_cfg_delay_us;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Buffer RAM interface; stamp and payload are stored side by side.
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    t_entry            rd_data;

    // Sequencer to output stage.
    logic    push;
    t_result push_data;
    logic    out_free;
    t_result out_data;

    tdf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tdf_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_delay_us   (r_delay_us),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_stamp   (i_in_stamp),
        .i_in_payload (i_in_payload),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .i_out_free   (out_free),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    tdf_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (out_data)
    );

    assign o_out_stamp   = out_data.stamp;
    assign o_out_payload = out_data.payload;
    assign o_out_last    = out_data.last;

endmodule

`default_nettype wire

FILE: design/tdf_checker.sv
// ============================================================================
// tdf_checker
// Port-level checks for the timestamp delay FIFO, bound to the top level.
// ============================================================================
`default_nettype none

module tdf_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            o_in_ready,
    input  wire logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    input  wire logic [tdf_pkg::STAMP_W-1:0]     o_out_stamp,
    input  wire logic [tdf_pkg::PAYLOAD_W-1:0]   o_out_payload,
    input  wire logic                            o_out_last
);

    // A result held by a stalled receiver must not change or vanish.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_stamp) && $stable(o_out_payload)
            && $stable(o_out_last))
        else $error("output changed while stalled");

    // Only one input is in flight: after a transaction the input side closes.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while previous one still in progress");

    // When ready for a new input, any waiting result must close its run.
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && o_out_valid |-> o_out_last)
        else $error("idle with an unfinished run in the output register");

endmodule

bind timestamp_delay_fifo tdf_checker u_tdf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_stamp   (o_out_stamp),
    .o_out_payload (o_out_payload),
    .o_out_last    (o_out_last)
);

`default_nettype wire

FILE: tb/sv/tdf_release_checker.sv
// ============================================================================
// tdf_release_checker
// Watches the configuration, input and output channels of the timestamp
// delay FIFO, keeps its own copy of the delay line, and compares every
// released message with the oldest predicted one.
// ============================================================================
`timescale 1ns / 100ps

module tdf_release_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [tdf_pkg::DELAY_W-1:0]   i_cfg_delay_us,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_ready,
    input  wire logic [tdf_pkg::STAMP_W-1:0]   i_in_stamp,
    input  wire logic [tdf_pkg::PAYLOAD_W-1:0] i_in_payload,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [tdf_pkg::STAMP_W-1:0]   i_out_stamp,
    input  wire logic [tdf_pkg::PAYLOAD_W-1:0] i_out_payload,
    input  wire logic                          i_out_last,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);
    import tdf_pkg::*;

    // Shadow copy of the delay line.
    logic [STAMP_W-1:0]   held_stamp   [DEPTH];
    logic [PAYLOAD_W-1:0] held_payload [DEPTH];
    int unsigned          oldest_idx;
    int unsigned          newest_idx;
    int unsigned          held_count;
    logic [DELAY_W-1:0]   hold_delay;

    t_result              release_queue [$];
    int                   fails   = 0;
    int                   checked = 0;

    function automatic int unsigned step_idx(input int unsigned idx);
        return (idx == DEPTH - 1) ? 0 : idx + 1;
    endfunction

    // Releases the oldest held message into the queue of expected results.
    task automatic drop_oldest();
        release_queue.push_back({held_stamp[oldest_idx], held_payload[oldest_idx], 1'b0});
        oldest_idx = step_idx(oldest_idx);
        held_count--;
    endtask

    task automatic hold_message(input logic [STAMP_W-1:0]   stamp,
                                input logic [PAYLOAD_W-1:0] payload);
        int                 released;
        logic [STAMP_W-1:0] span;
        bit                 draining;
        released = 0;
        if (hold_delay == '0) begin
            release_queue.push_back({stamp, payload, 1'b1});
        end else begin
            if (held_count >= DEPTH) begin
                drop_oldest();
                released++;
            end
            held_stamp[newest_idx]   = stamp;
            held_payload[newest_idx] = payload;
            newest_idx = step_idx(newest_idx);
            held_count++;
            draining = 1'b1;
            while (draining && held_count > 1 && released < DEPTH) begin
                // Span is taken modulo the stamp width, so wrapped stamps work.
                span = stamp - held_stamp[oldest_idx];
                if (span > STAMP_W'(hold_delay)) begin
                    drop_oldest();
                    released++;
                end else begin
                    draining = 1'b0;
                end
            end
            if (released > 0) begin
                release_queue[release_queue.size() - 1].last = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            oldest_idx = 0;
            newest_idx = 0;
            held_count = 0;
            hold_delay = DELAY_RESET;
            release_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                checked++;
                if (release_queue.size() == 0) begin
                    $error("unexpected message: stamp %h payload %h last %b",
                           i_out_stamp, i_out_payload, i_out_last);
                    fails++;
                end else begin
                    want = release_queue.pop_front();
                    if (i_out_stamp !== want.stamp) begin
                        $error("out_stamp mismatch: expected %h, actual %h",
                               want.stamp, i_out_stamp);
                        fails++;
                    end
                    if (i_out_payload !== want.payload) begin
                        $error("out_payload mismatch: expected %h, actual %h",
                               want.payload, i_out_payload);
                        fails++;
                    end
                    if (i_out_last !== want.last) begin
                        $error("out_last mismatch: expected %b, actual %b",
                               want.last, i_out_last);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                hold_delay = i_cfg_delay_us;
            end
            if (i_in_valid && i_in_ready) begin
                hold_message(i_in_stamp, i_in_payload);
            end
        end
        o_fail_count <= fails;
        o_pending    <= release_queue.size();
        o_checked    <= checked;
    end

endmodule

FILE: tb/sv/tb_timestamp_delay_fifo.sv
// ============================================================================
// tb_timestamp_delay_fifo
// Drives the timestamp delay FIFO with directed and random message streams
// under several delay settings and idle mixes, and reports the verdict.
// ============================================================================
`timescale 1ns / 100ps

module tb_timestamp_delay_fifo;

    import tdf_pkg::*;

    // Cycles allowed after the last expected message before the delay is
    // rewritten or the run ends. A transaction that releases nothing can
    // still be busy with its closing span check.
    localparam int SETTLE_CYCLES  = 20;
    // Cycles without any transaction on any channel before the run is
    // declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of each random phase and of the full-buffer burst.
    localparam int PHASE_ITEMS    = 45;
    localparam int NUM_PHASES     = 6;
    localparam int BURST_ITEMS    = 70;
    localparam int RANDOM_TOTAL   = NUM_PHASES * PHASE_ITEMS + BURST_ITEMS + 1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [DELAY_W-1:0]   i_cfg_delay_us;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [STAMP_W-1:0]   i_in_stamp;
    logic [PAYLOAD_W-1:0] i_in_payload;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [STAMP_W-1:0]   o_out_stamp;
    logic [PAYLOAD_W-1:0] o_out_payload;
    logic                 o_out_last;

    int                   fail_count;
    int                   pending;
    int                   checked;

    // Percentages of cycles in which the sender and the receiver hold off.
    int unsigned          tx_idle_pct = 36;
    int unsigned          rx_idle_pct = 45;

    int                   items_sent  = 0;
    int                   random_sent = 0;
    int                   cfg_writes  = 0;
    int                   idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    timestamp_delay_fifo u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_delay_us (i_cfg_delay_us),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_stamp     (i_in_stamp),
        .i_in_payload   (i_in_payload),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_stamp    (o_out_stamp),
        .o_out_payload  (o_out_payload),
        .o_out_last     (o_out_last)
    );

    tdf_release_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_delay_us (i_cfg_delay_us),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_stamp     (i_in_stamp),
        .i_in_payload   (i_in_payload),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_stamp    (o_out_stamp),
        .i_out_payload  (o_out_payload),
        .i_out_last     (o_out_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // The receiver decides afresh every cycle whether it accepts a message.
    // All stimulus is driven with nonblocking assignments at the rising edge,
    // so the block and the checker always sample settled values.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: any accepted transaction on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles, %0d messages outstanding",
                   idle_cycles, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Presents one message and waits until the block takes it. Valid stays
    // high across back-to-back transactions; only the stamp and payload change.
    task automatic send_item(input logic [STAMP_W-1:0]   stamp,
                             input logic [PAYLOAD_W-1:0] payload);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_in_stamp   <= stamp;
        i_in_payload <= payload;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Random-part transaction. The idle mix follows the progress through the
    // random part: receiver-heavy idling, then sender-heavy, then none.
    task automatic send_random_item(input logic [STAMP_W-1:0] stamp);
        if (random_sent < RANDOM_TOTAL / 3) begin
            tx_idle_pct = 36;
            rx_idle_pct = 45;
        end else if (random_sent < 2 * RANDOM_TOTAL / 3) begin
            tx_idle_pct = 45;
            rx_idle_pct = 36;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        random_sent++;
        send_item(stamp, $urandom());
    endtask

    // Holds the sender off until every predicted message has come out.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    // Rewrites the delay once the block has gone quiet.
    task automatic write_delay(input logic [DELAY_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_delay_us <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Picks the next stamp relative to the previous one. Most steps keep the
    // stream non-decreasing and land below, at, or just past the delay, or
    // jump far ahead to flush many messages at once. A few are arbitrary
    // stamps (which may go backwards) or start just below the wrap point.
    function automatic logic [STAMP_W-1:0] next_stamp(input logic [STAMP_W-1:0] prev,
                                                      input logic [DELAY_W-1:0] dly);
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(99);
        span = (dly == '0) ? 32'd1000 : 32'(dly);
        if (pick < 10) begin
            return prev;
        end else if (pick < 45) begin
            return prev + STAMP_W'($urandom_range(span / 4));
        end else if (pick < 65) begin
            return prev + STAMP_W'(span + $urandom_range(2)) - STAMP_W'(1);
        end else if (pick < 85) begin
            return prev + STAMP_W'($urandom_range(3 * span, span));
        end else if (pick < 95) begin
            return STAMP_W'({$urandom(), $urandom()});
        end else begin
            return '1 - STAMP_W'($urandom_range(span));
        end
    endfunction

    initial begin
        logic [STAMP_W-1:0] stamp;
        logic [DELAY_W-1:0] dly;

        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_delay_us <= '0;
        i_in_valid     <= 1'b0;
        i_in_stamp     <= '0;
        i_in_payload   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. With the reset delay of 100000 us, a span equal to
        // the delay holds the message back and one more microsecond
        // releases the oldest one.
        send_item(40'd0, 32'h0000_0000);
        send_item(40'd100000, 32'h5555_5555);
        send_item(40'd100001, 32'hFFFF_FFFF);

        // Passthrough: the two messages still held must stay put while these
        // go straight through, extreme field values included.
        write_delay('0);
        send_item('1, 32'hFFFF_FFFF);
        send_item(40'd0, 32'h0000_0000);
        send_item(40'hAA_AAAA_AAAA, 32'hAAAA_AAAA);

        // Full-scale delay: the held messages come out once the span passes
        // 2^24 - 1, and a span of exactly the delay releases nothing.
        write_delay('1);
        send_item(40'd100001 + 40'h100_0000, 32'h1234_5678);
        send_item(40'd100001 + 40'h100_0000 + 40'hFF_FFFF, 32'h8765_4321);
        send_item(40'd100002 + 40'h100_0000 + 40'hFF_FFFF, 32'h0F0F_0F0F);

        // Short delay with stamps that wrap past the top of the 40-bit range,
        // a repeated stamp, and stamps that go backwards.
        write_delay(24'd10);
        send_item(40'hFF_FFFF_FFFD, 32'hF0F0_F0F0);
        send_item(40'hFF_FFFF_FFFF, 32'h0000_0001);
        send_item(40'd5, 32'h8000_0000);
        send_item(40'd8, 32'h0000_FFFF);
        send_item(40'd8, 32'hFFFF_0000);
        send_item(40'd3, 32'h3333_3333);
        send_item(40'h80_0000_0000, 32'hCCCC_CCCC);

        // Smallest nonzero delay.
        write_delay(24'd1);
        send_item(40'h80_0000_0001, 32'h0000_0002);
        send_item(40'h80_0000_0002, 32'h0000_0004);

        // Random part: one phase per delay setting. Each phase pauses once
        // midway until the block has released everything it owes.
        stamp = 40'h80_0000_0002;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       dly = 24'd1;
                1:       dly = '0;
                2:       dly = '1;
                3:       dly = DELAY_RESET;
                4:       dly = DELAY_W'($urandom_range(300, 2));
                default: dly = DELAY_W'($urandom_range(24'hFF_FFFF, 1));
            endcase
            write_delay(dly);
            if (p == 2) begin
                // Fill the buffer well past its depth with closely spaced
                // stamps so the oldest message is forced out, then jump far
                // ahead to flush nearly the whole buffer in one transaction.
                for (int k = 0; k < BURST_ITEMS; k++) begin
                    stamp = stamp + STAMP_W'($urandom_range(100));
                    send_random_item(stamp);
                end
                stamp = stamp + 40'h200_0000 + STAMP_W'($urandom_range(1000));
                send_random_item(stamp);
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                stamp = next_stamp(stamp, dly);
                send_random_item(stamp);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d messages and checked %0d releases over %0d delay writes,",
                 items_sent, checked, cfg_writes);
        $display("from passthrough through 1 us to full scale, with wrap and full-buffer flush.");
        if (pending != 0) begin
            $error("%0d expected messages never came out", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/tdf_pkg.sv
design/tdf_ram.sv
design/tdf_out_stage.sv
design/tdf_seq.sv
design/timestamp_delay_fifo.sv
design/tdf_checker.sv
tb/sv/tdf_release_checker.sv
tb/sv/tb_timestamp_delay_fifo.sv
